/* rtl/gclw_pkg.sv */
// gclw_pkg: shared types, constants and helper functions of the g-code line word parser
package gclw_pkg;

  localparam int FRACTION_DIGITS_DEF = 4;
  localparam int VALUE_BITS_DEF      = 32;
  localparam int FD_W                = 3;
  localparam int PROD_W              = 28;

  typedef enum logic [1:0] {
    KIND_CMD = 2'd0,
    KIND_ARG = 2'd1,
    KIND_END = 2'd2
  } kind_e;

  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_POINT  = 8'h2E;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CASE_OFS  = 8'h20;
  localparam logic [7:0] CH_G      = 8'h47;
  localparam logic [7:0] CH_M      = 8'h4D;
  localparam logic [15:0] MODAL_MAX = 16'd3;
  localparam logic [15:0] SAT16     = 16'hFFFF;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         letter;
    logic [15:0]        code;
    logic [15:0]        subcode;
    logic signed [31:0] value;
  } res_t;

  function automatic logic [23:0] pow_ten(input logic [FD_W-1:0] e);
    logic [23:0] r;
    unique case (e)
      3'd0:    r = 24'd1;
      3'd1:    r = 24'd10;
      3'd2:    r = 24'd100;
      3'd3:    r = 24'd1000;
      3'd4:    r = 24'd10000;
      3'd5:    r = 24'd100000;
      3'd6:    r = 24'd1000000;
      default: r = 24'd10000000;
    endcase
    return r;
  endfunction

  // decimal digit accumulate, saturating at 16 bits
  function automatic logic [15:0] acc16(input logic [15:0] a, input logic [3:0] d);
    logic [19:0] t;
    t = ({4'b0, a} << 3) + ({4'b0, a} << 1) + {16'b0, d};
    return (t > {4'b0, SAT16}) ? SAT16 : t[15:0];
  endfunction

endpackage

/* rtl/gclw_in_if.sv */
// gclw_in_if: character channel of the g-code line word parser
interface gclw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] character;
  logic       line_end;

  modport source (output valid, output character, output line_end, input ready);
  modport sink   (input valid, input character, input line_end, output ready);
endinterface

/* rtl/gclw_out_if.sv */
// gclw_out_if: word result channel of the g-code line word parser
interface gclw_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         letter;
  logic [15:0]        code;
  logic [15:0]        subcode;
  logic signed [31:0] value;
  logic               last;

  modport source (output valid, output kind, output letter, output code, output subcode,
                  output value, output last, input ready);
  modport sink   (input valid, input kind, input letter, input code, input subcode,
                  input value, input last, output ready);
endinterface

/* rtl/gcode_line_word_parser.sv */
// gcode_line_word_parser: g-code line tokenizer, characters in, command and argument words out
//
//   channel  direction  payload                                   results per transaction
//   in_i     sink       character, line_end                       -
//   out_o    source     kind, letter, code, subcode, value, last  0 to 3
//
// one character per cycle while ready; its scan state update and results form in that cycle
// results sit in a three-entry result register and leave one per cycle while out_o is ready
// a new character is taken once the result register holds at most one result being taken, so
// characters with one result or none stream at one per cycle; after others the next one waits
// rst_ni clears scan state and modal command and empties the result register; no clearing pass
module gcode_line_word_parser #(
  parameter int FRACTION_DIGITS = gclw_pkg::FRACTION_DIGITS_DEF,
  parameter int VALUE_BITS      = gclw_pkg::VALUE_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  gclw_in_if.sink     in_i,
  gclw_out_if.source  out_o
);

  localparam int SW = ((VALUE_BITS > gclw_pkg::PROD_W) ? VALUE_BITS : gclw_pkg::PROD_W) + 1;
  localparam int VW = (SW > 32) ? SW : 32;
  localparam logic [SW-1:0] LIM       = SW'(1) << (VALUE_BITS - 1);
  localparam logic [SW-1:0] LIM_DIV10 = LIM / 10;
  localparam logic [gclw_pkg::FD_W-1:0] FD_MAX = gclw_pkg::FD_W'(FRACTION_DIGITS);

  typedef enum logic [1:0] {
    MODE_TEXT  = 2'd0,
    MODE_PAREN = 2'd1,
    MODE_LINE  = 2'd2
  } mode_e;

  mode_e                     mode_q, mode_d;
  logic [7:0]                letter_q, letter_d;
  logic [15:0]               ipart_q, ipart_d;
  logic [15:0]               fpart_q, fpart_d;
  logic [gclw_pkg::FD_W-1:0] fdig_q, fdig_d;
  logic                      neg_q, neg_d;
  logic                      pend_q, pend_d;
  logic                      cstart_q, cstart_d;
  logic [15:0]               mcode_q, mcode_d;
  logic [15:0]               msub_q, msub_d;
  logic [SW-1:0]             mag_q, mag_d;
  logic                      point_q, point_d;
  logic                      just_q, just_d;
  gclw_pkg::res_t            res_q [3];
  gclw_pkg::res_t            res_d [3];
  logic [1:0]                cnt_q, cnt_d;

  logic                      fire, take;
  logic [7:0]                ch;
  logic                      is_digit, is_sign, is_point, is_space;
  logic [3:0]                dig;
  logic                      is_cmd, has_a, close, has_c, done;
  gclw_pkg::res_t            res_a, res_b, res_c;
  logic [SW-1:0]             mag10, base, addv;
  logic [gclw_pkg::FD_W-1:0] pexp;
  logic [gclw_pkg::PROD_W-1:0] prod;
  logic [VW-1:0]             vpos, vsel;
  logic [1:0]                n_res;

  assign take         = out_o.valid && out_o.ready;
  assign in_i.ready   = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_o.ready);
  assign fire         = in_i.valid && in_i.ready;
  assign ch           = in_i.character;

  assign out_o.valid   = (cnt_q != 2'd0);
  assign out_o.kind    = res_q[0].kind;
  assign out_o.letter  = res_q[0].letter;
  assign out_o.code    = res_q[0].code;
  assign out_o.subcode = res_q[0].subcode;
  assign out_o.value   = res_q[0].value;
  assign out_o.last    = (cnt_q == 2'd1);

  assign is_digit = (ch >= gclw_pkg::CH_ZERO) && (ch <= gclw_pkg::CH_NINE);
  assign is_sign  = (ch == gclw_pkg::CH_PLUS) || (ch == gclw_pkg::CH_MINUS);
  assign is_point = (ch == gclw_pkg::CH_POINT);
  assign is_space = (ch == gclw_pkg::CH_SPACE) || (ch == gclw_pkg::CH_NUL) ||
                    ((ch >= gclw_pkg::CH_TAB) && (ch <= gclw_pkg::CH_CR));
  assign dig      = 4'(ch - gclw_pkg::CH_ZERO);

  // digit accumulate into the scaled magnitude
  assign mag10 = (mag_q > LIM_DIV10) ? LIM : ((mag_q << 3) + (mag_q << 1));
  assign base  = point_q ? mag_q : mag10;
  assign pexp  = point_q ? (FD_MAX - fdig_q - 1'b1) : FD_MAX;
  assign prod  = gclw_pkg::PROD_W'(dig) * gclw_pkg::PROD_W'(gclw_pkg::pow_ten(pexp));
  assign addv  = (point_q && (fdig_q >= FD_MAX)) ? '0 : SW'(prod);

  // argument value with saturation
  assign vpos = (mag_q >= LIM) ? VW'(LIM - 1'b1) : VW'(mag_q);
  assign vsel = neg_q ? (~VW'(mag_q) + 1'b1) : vpos;

  // results of closing the pending word
  assign is_cmd = (letter_q == gclw_pkg::CH_G) || (letter_q == gclw_pkg::CH_M);
  assign has_a  = is_cmd ? !cstart_q : cstart_q;

  always_comb begin
    res_c = '{kind: gclw_pkg::KIND_END, letter: '0, code: '0, subcode: '0, value: '0};
    if (is_cmd) begin
      res_a = res_c;
      res_b = '{kind: gclw_pkg::KIND_CMD, letter: letter_q, code: ipart_q,
                subcode: fpart_q, value: '0};
    end else begin
      res_a = '{kind: gclw_pkg::KIND_CMD, letter: gclw_pkg::CH_G, code: mcode_q,
                subcode: msub_q, value: '0};
      res_b = '{kind: gclw_pkg::KIND_ARG, letter: letter_q, code: '0, subcode: '0,
                value: vsel[31:0]};
    end
  end

  always_comb begin
    mode_d   = mode_q;
    letter_d = letter_q;
    ipart_d  = ipart_q;
    fpart_d  = fpart_q;
    fdig_d   = fdig_q;
    neg_d    = neg_q;
    pend_d   = pend_q;
    cstart_d = cstart_q;
    mcode_d  = mcode_q;
    msub_d   = msub_q;
    mag_d    = mag_q;
    point_d  = point_q;
    just_d   = just_q;
    close    = 1'b0;
    has_c    = 1'b0;
    done     = 1'b0;

    if (fire) begin
      if (in_i.line_end) begin
        close = pend_q;
        has_c = 1'b1;
      end else if (pend_q) begin
        priority if (is_sign && just_q) begin
          neg_d  = (ch == gclw_pkg::CH_MINUS);
          just_d = 1'b0;
          done   = 1'b1;
        end else if (is_digit) begin
          just_d = 1'b0;
          done   = 1'b1;
          mag_d  = (addv > (LIM - base)) ? LIM : (base + addv);
          if (!point_q) begin
            ipart_d = gclw_pkg::acc16(ipart_q, dig);
          end else begin
            fpart_d = gclw_pkg::acc16(fpart_q, dig);
            if (fdig_q < FD_MAX) begin
              fdig_d = fdig_q + 1'b1;
            end
          end
        end else if (is_point && !point_q) begin
          point_d = 1'b1;
          just_d  = 1'b0;
          done    = 1'b1;
        end else begin
          close = 1'b1;
        end
      end

      if (close) begin
        cstart_d = 1'b0;
        pend_d   = 1'b0;
        if ((letter_q == gclw_pkg::CH_G) && (ipart_q <= gclw_pkg::MODAL_MAX)) begin
          mcode_d = ipart_q;
          msub_d  = fpart_q;
        end
      end

      if (in_i.line_end) begin
        mode_d   = MODE_TEXT;
        cstart_d = 1'b1;
        pend_d   = 1'b0;
      end else if (!done) begin
        unique case (mode_q)
          MODE_PAREN: begin
            if (ch == gclw_pkg::CH_RPAREN) begin
              mode_d = MODE_TEXT;
            end
          end
          MODE_LINE: begin
            mode_d = MODE_LINE;
          end
          default: begin
            priority if (is_space) begin
              mode_d = mode_q;
            end else if (ch == gclw_pkg::CH_SEMI) begin
              mode_d = MODE_LINE;
            end else if (ch == gclw_pkg::CH_LPAREN) begin
              mode_d = MODE_PAREN;
            end else begin
              letter_d = ((ch >= gclw_pkg::CH_LOW_A) && (ch <= gclw_pkg::CH_LOW_Z)) ?
                         (ch - gclw_pkg::CASE_OFS) : ch;
              ipart_d  = '0;
              fpart_d  = '0;
              fdig_d   = '0;
              neg_d    = 1'b0;
              mag_d    = '0;
              point_d  = 1'b0;
              just_d   = 1'b1;
              pend_d   = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // pack the results of this transaction into the result register, or shift it by one on a take
  always_comb begin
    n_res    = 2'(close && has_a) + 2'(close) + 2'(has_c);
    res_d[0] = res_q[1];
    res_d[1] = res_q[2];
    res_d[2] = res_q[2];
    cnt_d    = cnt_q;
    if (fire) begin
      res_d[0] = (close && has_a) ? res_a : (close ? res_b : res_c);
      res_d[1] = (close && has_a) ? res_b : res_c;
      res_d[2] = res_c;
      cnt_d    = n_res;
    end else if (take) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_TEXT;
      letter_q <= '0;
      ipart_q  <= '0;
      fpart_q  <= '0;
      fdig_q   <= '0;
      neg_q    <= 1'b0;
      pend_q   <= 1'b0;
      cstart_q <= 1'b1;
      mcode_q  <= '0;
      msub_q   <= '0;
      mag_q    <= '0;
      point_q  <= 1'b0;
      just_q   <= 1'b0;
      cnt_q    <= '0;
    end else begin
      mode_q   <= mode_d;
      letter_q <= letter_d;
      ipart_q  <= ipart_d;
      fpart_q  <= fpart_d;
      fdig_q   <= fdig_d;
      neg_q    <= neg_d;
      pend_q   <= pend_d;
      cstart_q <= cstart_d;
      mcode_q  <= mcode_d;
      msub_q   <= msub_d;
      mag_q    <= mag_d;
      point_q  <= point_d;
      just_q   <= just_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire || take) begin
      res_q[0] <= res_d[0];
      res_q[1] <= res_d[1];
      res_q[2] <= res_d[2];
    end
  end

  // a word is only ever open in normal text
  a_pend_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (mode_q == MODE_TEXT))
    else $error("word open inside a comment");

  // line end leaves a fresh line and at least its end-of-command result
  a_line_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.line_end) |=> (!pend_q && cstart_q && out_o.valid))
    else $error("line end not closed");

  // scaled magnitude never passes the saturation bound
  a_mag_lim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mag_q <= LIM)
    else $error("magnitude above bound");

  // an argument word never carries a command letter
  a_arg_letter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (res_q[0].kind == gclw_pkg::KIND_ARG)) |->
    ((res_q[0].letter != gclw_pkg::CH_G) && (res_q[0].letter != gclw_pkg::CH_M)))
    else $error("argument with command letter");

  // the final result of a line end transaction is an end of command
  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && in_i.line_end) |=>
    ((cnt_q == 2'd1 && res_q[0].kind == gclw_pkg::KIND_END) ||
     (cnt_q == 2'd2 && res_q[1].kind == gclw_pkg::KIND_END) ||
     (cnt_q == 2'd3 && res_q[2].kind == gclw_pkg::KIND_END)))
    else $error("line end without end of command");

endmodule
